[hw/rtl/crhc_pkg.sv]
package crhc_pkg;

    localparam int unsigned NOW_W  = 32;
    localparam int unsigned TEMP_W = 12;
    localparam int unsigned SP_W   = 8;
    localparam int unsigned BAND_W = 6;
    localparam int unsigned REST_W = 3;
    localparam int unsigned CMP_W  = 14;
    localparam int unsigned RMS_W  = 19;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned RES_W      = 5;
    localparam int unsigned ADDR_W     = 5;

    localparam logic [NOW_W-1:0] START_DELAY_MS = 32'd5000;
    localparam logic [RMS_W-1:0] REST_UNIT_MS   = 19'd60000;
    localparam logic [REST_W-1:0] REST_MAX_MIN  = 3'd5;

    localparam logic [2:0] REG_DEVICE_ENABLE  = 3'd0;
    localparam logic [2:0] REG_FAN_ENABLE     = 3'd1;
    localparam logic [2:0] REG_INLET_SP       = 3'd2;
    localparam logic [2:0] REG_INLET_BAND     = 3'd3;
    localparam logic [2:0] REG_REST_MINUTES   = 3'd4;
    localparam logic [2:0] REG_AF_SP          = 3'd5;
    localparam logic [2:0] REG_AF_BAND        = 3'd6;
    localparam logic [2:0] REG_FAN_SP         = 3'd7;

    typedef struct packed {
        logic                     filter_alarm;
        logic                     door_closed;
        logic                     fan_sensor_valid;
        logic signed [TEMP_W-1:0] fan_sensor_temp;
        logic                     antifreeze_valid;
        logic signed [TEMP_W-1:0] antifreeze_temp;
        logic                     inlet_valid;
        logic signed [TEMP_W-1:0] inlet_temp;
        logic [NOW_W-1:0]         now_ms;
    } tick_t;

    typedef struct packed {
        logic rest_pending;
        logic fan_on;
        logic compressor_on;
        logic condenser_on;
        logic evaporator_on;
    } relay_t;

    // rest time in ms; above the max it disables the rest
    function automatic logic [RMS_W-1:0] rest_time(input logic [REST_W-1:0] minutes);
        logic [RMS_W-1:0] r;
        begin
            if (minutes > REST_MAX_MIN)
            begin
                r = '0;
            end
            else
            begin
                r = RMS_W'(minutes * REST_UNIT_MS);
            end
            return r;
        end
    endfunction

    // whole degrees times ten, as a signed compare value
    function automatic logic signed [CMP_W-1:0] times_ten(input logic signed [CMP_W-1:0] x);
        return (x <<< 3) + (x <<< 1);
    endfunction

endpackage

[hw/rtl/chiller_relay_hysteresis_control.sv]
// channel   direction  handshake               payload
// s_*       in         s_tvalid/s_tready       s_tdata: one tick (80 bits)
// m_*       out        m_tvalid/m_tready       m_tdata: relay word (8 bits)
// apb       in         psel&penable&pwrite     paddr/pwdata/prdata, 8 registers
//
// One word per cycle sustained while the output is not stalled. A tick is
// registered on entry, evaluated by one level of compare logic against the
// relay state and registered again on exit. The relay state updates in the
// same cycle the result register loads. A stalled output holds both stages;
// the input side still takes a word while its own register is empty. Reset
// clears valid flags, config registers, relay state and stamps, not data words.
module chiller_relay_hysteresis_control
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // now_ms[31:0], inlet_temp[43:32], inlet_valid[44], antifreeze_temp[56:45],
    // antifreeze_valid[57], fan_sensor_temp[69:58], fan_sensor_valid[70],
    // door_closed[71], filter_alarm[72], zero[79:73]
    input  logic [crhc_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // evaporator_on[0], condenser_on[1], compressor_on[2], fan_on[3],
    // rest_pending[4], zero[7:5]
    output logic [crhc_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crhc_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic                                     device_enable_reg;
    logic                                     fan_enable_reg;
    logic signed [crhc_pkg::SP_W-1:0]         inlet_sp_reg;
    logic [crhc_pkg::BAND_W-1:0]              inlet_band_reg;
    logic [crhc_pkg::REST_W-1:0]              rest_minutes_reg;
    logic signed [crhc_pkg::SP_W-1:0]         af_sp_reg;
    logic [crhc_pkg::BAND_W-1:0]              af_band_reg;
    logic signed [crhc_pkg::SP_W-1:0]         fan_sp_reg;

    logic                                     in_valid_reg;
    crhc_pkg::tick_t                          in_word_reg;
    logic                                     out_valid_reg;
    crhc_pkg::relay_t                         out_word_reg;
    crhc_pkg::relay_t                         out_word_next;

    logic                                     condenser_reg;
    logic                                     condenser_next;
    logic                                     compressor_reg;
    logic                                     compressor_next;
    logic                                     evaporator_reg;
    logic                                     evaporator_next;
    logic                                     fan_reg;
    logic                                     fan_next;
    logic [crhc_pkg::NOW_W-1:0]               start_stamp_reg;
    logic [crhc_pkg::NOW_W-1:0]               start_stamp_next;
    logic [crhc_pkg::NOW_W-1:0]               stop_stamp_reg;
    logic [crhc_pkg::NOW_W-1:0]               stop_stamp_next;

    logic                                     advance;
    logic                                     fire;
    logic                                     cfg_write;
    logic [2:0]                               cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_enable_reg <= 1'b0;
            fan_enable_reg    <= 1'b0;
            inlet_sp_reg      <= '0;
            inlet_band_reg    <= '0;
            rest_minutes_reg  <= '0;
            af_sp_reg         <= '0;
            af_band_reg       <= '0;
            fan_sp_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                crhc_pkg::REG_DEVICE_ENABLE: device_enable_reg <= pwdata[0];
                crhc_pkg::REG_FAN_ENABLE:    fan_enable_reg    <= pwdata[0];
                crhc_pkg::REG_INLET_SP:      inlet_sp_reg      <= pwdata[7:0];
                crhc_pkg::REG_INLET_BAND:    inlet_band_reg    <= pwdata[5:0];
                crhc_pkg::REG_REST_MINUTES:  rest_minutes_reg  <= pwdata[2:0];
                crhc_pkg::REG_AF_SP:         af_sp_reg         <= pwdata[7:0];
                crhc_pkg::REG_AF_BAND:       af_band_reg       <= pwdata[5:0];
                crhc_pkg::REG_FAN_SP:        fan_sp_reg        <= pwdata[7:0];
                default:                     fan_sp_reg        <= fan_sp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            crhc_pkg::REG_DEVICE_ENABLE: prdata = {31'd0, device_enable_reg};
            crhc_pkg::REG_FAN_ENABLE:    prdata = {31'd0, fan_enable_reg};
            crhc_pkg::REG_INLET_SP:      prdata = {24'd0, inlet_sp_reg};
            crhc_pkg::REG_INLET_BAND:    prdata = {26'd0, inlet_band_reg};
            crhc_pkg::REG_REST_MINUTES:  prdata = {29'd0, rest_minutes_reg};
            crhc_pkg::REG_AF_SP:         prdata = {24'd0, af_sp_reg};
            crhc_pkg::REG_AF_BAND:       prdata = {26'd0, af_band_reg};
            crhc_pkg::REG_FAN_SP:        prdata = {24'd0, fan_sp_reg};
            default:                     prdata = '0;
        endcase
    end

    // pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_word_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata[$bits(crhc_pkg::tick_t)-1:0];
        end
        if (fire)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // relay evaluation
    always_comb
    begin
        logic                                 base;
        logic                                 pending;
        logic                                 rest_ok;
        logic [crhc_pkg::NOW_W-1:0]           start_eff;
        logic [crhc_pkg::RMS_W-1:0]           rest_ms;
        logic signed [crhc_pkg::CMP_W-1:0]    af_hi;
        logic signed [crhc_pkg::CMP_W-1:0]    af_lo;
        logic signed [crhc_pkg::CMP_W-1:0]    in_hi;
        logic signed [crhc_pkg::CMP_W-1:0]    in_lo;
        logic signed [crhc_pkg::CMP_W-1:0]    fan_lo;
        logic signed [crhc_pkg::CMP_W-1:0]    af_t;
        logic signed [crhc_pkg::CMP_W-1:0]    in_t;
        logic signed [crhc_pkg::CMP_W-1:0]    fan_t;
        logic [crhc_pkg::NOW_W-1:0]           now;

        now     = in_word_reg.now_ms;
        base    = device_enable_reg && in_word_reg.door_closed && !in_word_reg.filter_alarm;
        pending = 1'b0;
        rest_ms = crhc_pkg::rest_time(rest_minutes_reg);
        rest_ok = (rest_ms == '0) || (stop_stamp_reg == '0)
                  || ((now - stop_stamp_reg) >= crhc_pkg::NOW_W'(rest_ms));

        af_hi  = crhc_pkg::times_ten(crhc_pkg::CMP_W'(af_sp_reg)
                                     + $signed({8'd0, af_band_reg}));
        in_hi  = crhc_pkg::times_ten(crhc_pkg::CMP_W'(inlet_sp_reg)
                                     + $signed({8'd0, inlet_band_reg}));
        af_lo  = crhc_pkg::times_ten(crhc_pkg::CMP_W'(af_sp_reg));
        in_lo  = crhc_pkg::times_ten(crhc_pkg::CMP_W'(inlet_sp_reg));
        fan_lo = crhc_pkg::times_ten(crhc_pkg::CMP_W'(fan_sp_reg));
        af_t   = crhc_pkg::CMP_W'(in_word_reg.antifreeze_temp);
        in_t   = crhc_pkg::CMP_W'(in_word_reg.inlet_temp);
        fan_t  = crhc_pkg::CMP_W'(in_word_reg.fan_sensor_temp);

        condenser_next   = condenser_reg;
        compressor_next  = compressor_reg;
        start_stamp_next = start_stamp_reg;
        stop_stamp_next  = stop_stamp_reg;
        start_eff        = condenser_reg ? start_stamp_reg : now;

        evaporator_next = base && in_word_reg.inlet_valid;

        priority if (!(base && in_word_reg.antifreeze_valid && in_word_reg.inlet_valid))
        begin
            condenser_next   = 1'b0;
            compressor_next  = 1'b0;
            start_stamp_next = '0;
        end
        else if (af_t > af_hi)
        begin
            priority if (in_t >= in_hi)
            begin
                condenser_next   = 1'b1;
                start_stamp_next = start_eff;
                if (rest_ok)
                begin
                    compressor_next = (now - start_eff) >= crhc_pkg::START_DELAY_MS;
                end
                else
                begin
                    pending = 1'b1;
                end
            end
            else if (in_t < in_lo)
            begin
                condenser_next   = 1'b0;
                compressor_next  = 1'b0;
                start_stamp_next = '0;
            end
            else
            begin
                condenser_next = compressor_reg;
            end
        end
        else if (af_t <= af_lo)
        begin
            condenser_next   = 1'b0;
            compressor_next  = 1'b0;
            start_stamp_next = '0;
        end
        else
        begin
            condenser_next = compressor_reg;
        end

        // compressor stop: stamp it and drop the start stamp
        if (compressor_reg && !compressor_next)
        begin
            stop_stamp_next  = now;
            start_stamp_next = '0;
        end

        fan_next = base && fan_enable_reg && in_word_reg.fan_sensor_valid && (fan_t > fan_lo);

        out_word_next.evaporator_on = evaporator_next;
        out_word_next.condenser_on  = condenser_next;
        out_word_next.compressor_on = compressor_next;
        out_word_next.fan_on        = fan_next;
        out_word_next.rest_pending  = pending;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            condenser_reg   <= 1'b0;
            compressor_reg  <= 1'b0;
            evaporator_reg  <= 1'b0;
            fan_reg         <= 1'b0;
            start_stamp_reg <= '0;
            stop_stamp_reg  <= '0;
        end
        else if (fire)
        begin
            condenser_reg   <= condenser_next;
            compressor_reg  <= compressor_next;
            evaporator_reg  <= evaporator_next;
            fan_reg         <= fan_next;
            start_stamp_reg <= start_stamp_next;
            stop_stamp_reg  <= stop_stamp_next;
        end
    end

    a_comp_needs_cond: assert property (@(posedge clk) disable iff (!rst_n)
        compressor_reg |-> condenser_reg && evaporator_reg)
        else $error("compressor on without condenser or evaporator");

    a_pending_cond: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.rest_pending |-> out_word_reg.condenser_on)
        else $error("rest hold reported with condenser off");

    a_stop_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        stop_stamp_reg != $past(stop_stamp_reg) |-> $fell(compressor_reg))
        else $error("stop stamp moved without a compressor stop");

    a_fan_base: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fan_next |-> device_enable_reg && fan_enable_reg)
        else $error("fan on while disabled");

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_word_reg.fan_on == fan_reg
                          && out_word_reg.evaporator_on == evaporator_reg)
        else $error("pending word differs from relay state");

endmodule
